[src/dmtt_pkg.sv]
package dmtt_pkg;

  // Number of mantissa digits that fit in the text (one more slot holds the point).
  localparam int DIGITS       = 14;
  localparam int MANT_W       = 50;
  localparam int PT_W         = 4;
  localparam int CHAR_W       = 8;
  localparam int BCD_W        = 4 * DIGITS;
  localparam int BITS_PER_STEP = 4;
  localparam int CONV_STEPS   = (MANT_W + BITS_PER_STEP - 1) / BITS_PER_STEP;
  localparam int SR_W         = CONV_STEPS * BITS_PER_STEP;
  localparam int STEP_W       = $clog2(CONV_STEPS);
  localparam int CNT_W        = $clog2(DIGITS + 2);
  localparam int IDX_W        = $clog2(DIGITS);

  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CHAR_POINT = 8'h2E;

  typedef struct packed {
    logic load;
    logic step;
    logic trim;
    logic emit;
  } dmtt_cmd_t;

  typedef struct packed {
    logic conv_last;
    logic empty;
    logic last;
  } dmtt_status_t;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_CONV = 4'b0010,
    ST_TRIM = 4'b0100,
    ST_EMIT = 4'b1000
  } dmtt_state_t;

  // Shift BITS_PER_STEP bits, msb first, into a BCD word (add-3 before each shift).
  // The top digit's carry falls off, so the word tracks the value modulo 10^DIGITS.
  function automatic logic [BCD_W-1:0] dabble_step(input logic [BCD_W-1:0] bcd_in,
                                                   input logic [BITS_PER_STEP-1:0] bits);
    logic [BCD_W-1:0] acc;
    logic [3:0]       dg;
    acc = bcd_in;
    for (int b = BITS_PER_STEP - 1; b >= 0; b--) begin
      for (int d = 0; d < DIGITS; d++) begin
        dg = acc[4*d +: 4];
        if (dg >= 4'd5) begin
          acc[4*d +: 4] = dg + 4'd3;
        end
      end
      acc = {acc[BCD_W-2:0], bits[b]};
    end
    return acc;
  endfunction

endpackage

[src/dmtt_ctrl.sv]
module dmtt_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  dmtt_pkg::dmtt_status_t status,
  output dmtt_pkg::dmtt_cmd_t    cmd,
  output logic                  busy
);
  import dmtt_pkg::*;

  dmtt_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      ST_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = ST_CONV;
        end
      end
      ST_CONV: begin
        cmd.step = 1'b1;
        if (status.conv_last) begin
          state_next = ST_TRIM;
        end
      end
      ST_TRIM: begin
        cmd.trim   = 1'b1;
        state_next = ST_EMIT;
      end
      ST_EMIT: begin
        // drop straight back when every slot was stripped
        if (status.empty) begin
          state_next = ST_IDLE;
        end else begin
          cmd.emit = 1'b1;
          if (status.last) begin
            state_next = ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  assign busy = (state != ST_IDLE);

endmodule

[src/dmtt_datapath.sv]
module dmtt_datapath (
  input  logic                          clk,
  input  logic                          rst,
  input  dmtt_pkg::dmtt_cmd_t           cmd,
  output dmtt_pkg::dmtt_status_t        status,
  input  logic                          cfg_write,
  input  logic [dmtt_pkg::PT_W-1:0]     cfg_data,
  input  logic [dmtt_pkg::MANT_W-1:0]   mantissa_value,
  input  logic [dmtt_pkg::PT_W-1:0]     point_position,
  output logic [dmtt_pkg::CHAR_W-1:0]   text_char,
  output logic                          last_char,
  output logic                          char_valid
);
  import dmtt_pkg::*;

  logic [PT_W-1:0]   min_frac;
  logic [SR_W-1:0]   mant_sr;
  logic [BCD_W-1:0]  bcd;
  logic [STEP_W-1:0] step_cnt;
  logic [PT_W-1:0]   dp;
  logic [CNT_W-1:0]  len;
  logic [CNT_W-1:0]  pos;

  logic [3:0]        digs [DIGITS];
  logic [PT_W-1:0]   k_next;
  logic [CNT_W-1:0]  len_next;
  logic [CNT_W-1:0]  int_cnt;
  logic [IDX_W-1:0]  idx;
  logic [CHAR_W-1:0] char_next;

  always_comb begin
    for (int d = 0; d < DIGITS; d++) begin
      digs[d] = bcd[4*d +: 4];
    end
  end

  // Lowest fractional digit that survives stripping; dp when none does.
  always_comb begin
    k_next = dp;
    for (int j = DIGITS - 1; j >= 0; j--) begin
      if (PT_W'(j) < dp) begin
        if ((digs[j] != 4'd0) || ((dp - PT_W'(j)) <= min_frac)) begin
          k_next = PT_W'(j);
        end
      end
    end
    if (k_next < dp) begin
      len_next = CNT_W'(DIGITS + 1) - CNT_W'(k_next);
    end else begin
      len_next = CNT_W'(DIGITS) - CNT_W'(dp);
    end
  end

  // Integer digits first, then the point, then the kept fraction.
  always_comb begin
    int_cnt   = CNT_W'(DIGITS) - CNT_W'(dp);
    idx       = '0;
    char_next = CHAR_POINT;
    if (pos < int_cnt) begin
      idx       = IDX_W'(CNT_W'(DIGITS - 1) - pos);
      char_next = CHAR_ZERO + {4'b0000, digs[idx]};
    end else if (pos != int_cnt) begin
      idx       = IDX_W'(CNT_W'(DIGITS) - pos);
      char_next = CHAR_ZERO + {4'b0000, digs[idx]};
    end
  end

  assign status.conv_last = (step_cnt == STEP_W'(CONV_STEPS - 1));
  assign status.empty     = (len == '0);
  assign status.last      = (pos == len - CNT_W'(1));

  always_ff @(posedge clk) begin
    if (rst) begin
      min_frac   <= '0;
      char_valid <= 1'b0;
    end else begin
      if (cfg_write) begin
        min_frac <= cfg_data;
      end
      char_valid <= cmd.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mant_sr  <= {{(SR_W - MANT_W){1'b0}}, mantissa_value};
      bcd      <= '0;
      step_cnt <= '0;
      dp       <= (point_position > PT_W'(DIGITS)) ? PT_W'(DIGITS) : point_position;
    end
    if (cmd.step) begin
      bcd      <= dabble_step(bcd, mant_sr[SR_W-1 -: BITS_PER_STEP]);
      mant_sr  <= mant_sr << BITS_PER_STEP;
      step_cnt <= step_cnt + STEP_W'(1);
    end
    if (cmd.trim) begin
      len <= len_next;
      pos <= '0;
    end
    if (cmd.emit) begin
      pos       <= pos + CNT_W'(1);
      text_char <= char_next;
      last_char <= status.last;
    end
  end

endmodule

[src/decimal_mantissa_to_text.sv]
// decimal_mantissa_to_text
// Turns a binary mantissa plus a point position into variable-length ASCII decimal
// text, one character per output cycle, most significant first, leading zeros kept.
// Request channel: drive mantissa_value and point_position with start high; the
//   request is taken at a rising edge where start is high and busy is low.
// Result channel: each character sits on text_char for exactly one cycle with
//   char_valid high; last_char marks the final character. The receiver cannot
//   stall, so characters leave on consecutive cycles with no gaps.
// Configuration: cfg_write with cfg_data loads min_fraction_digits; write it
//   only while busy is low and no characters are pending.
// Sequence: load, conversion (four mantissa bits per cycle into a shift-add-3
//   BCD register), trim, then emission of the characters, up to 15. A new
//   request is taken only once busy is low again, after the last character has
//   been issued. When every slot is stripped no character comes out at all; the
//   controller still enters the emit state and then returns to idle.
// Reset: rst (synchronous, active high) returns the controller to idle, drops
//   char_valid and clears min_fraction_digits to zero.
module decimal_mantissa_to_text (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic [dmtt_pkg::MANT_W-1:0] mantissa_value,
  input  logic [dmtt_pkg::PT_W-1:0]   point_position,
  input  logic                        cfg_write,
  input  logic [dmtt_pkg::PT_W-1:0]   cfg_data,
  output logic [dmtt_pkg::CHAR_W-1:0] text_char,
  output logic                        last_char,
  output logic                        char_valid
);
  import dmtt_pkg::*;

  dmtt_cmd_t    cmd;
  dmtt_status_t status;

  // Sequence the request: load, convert, trim, emit.
  dmtt_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .status (status),
    .cmd    (cmd),
    .busy   (busy)
  );

  // Hold the digits, find the strip point and drive the character register.
  dmtt_datapath u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .status         (status),
    .cfg_write      (cfg_write),
    .cfg_data       (cfg_data),
    .mantissa_value (mantissa_value),
    .point_position (point_position),
    .text_char      (text_char),
    .last_char      (last_char),
    .char_valid     (char_valid)
  );

  // A character only follows a cycle of work on a request.
  a_char_after_busy: assert property (@(posedge clk) disable iff (rst)
    char_valid |-> $past(busy))
    else $error("character emitted without an active request");

  // An accepted request starts work on the next cycle.
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted request did not raise busy");

  // The last character closes the request.
  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    (char_valid && last_char) |-> !busy)
    else $error("still busy after the last character");

  // Characters of one request come without gaps.
  a_no_gap: assert property (@(posedge clk) disable iff (rst)
    (char_valid && !last_char) |=> char_valid)
    else $error("gap inside a character sequence");

endmodule
